/* hw/rtl/dav_pkg.sv */
// Shared types and constants of the dynamic Allan variance engine.
package dav_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CNT_W    = 24;
    localparam int LAG_W    = 7;
    localparam int VAL_W    = 64;
    localparam int SUM_W    = 60;
    localparam int QUO_W    = 80;
    localparam int DIVR_W   = 24;
    localparam int POS_W    = 26;
    localparam int DIFF_W   = 27;
    localparam int SQ_W     = 52;
    localparam int FRAC_W   = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0]
    {
        REG_WINDOW_SIZE     = 2'd0,
        REG_STEP_SIZE       = 2'd1,
        REG_SAMPLE_INTERVAL = 2'd2,
        REG_RECORD_LENGTH   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0]
    {
        PASS_LAG   = 2'd0,
        PASS_TAU_A = 2'd1,
        PASS_TAU_B = 2'd2,
        PASS_LEN   = 2'd3
    } div_pass_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_LAG,
        ST_RD_LO,
        ST_RD_MID,
        ST_RD_HI,
        ST_SUM_D,
        ST_SQUARE,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

/* hw/rtl/dav_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module dav_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/dynamic_allan_variance_engine_unit.sv */
// Top level of the dynamic Allan variance engine.
//
// Phase samples enter on the s_ stream (24-bit signed in s_tdata), one
// transaction per sample, and are written into a ring RAM of RING_DEPTH
// entries (a power of two) addressed by sample number. Windows are centred
// every step_size samples; when a sample completes a window the block works
// through lags 1 .. Nw/3 (Nw the clamped window size) and sends one m_
// transaction per lag, m_tlast marking the largest lag of the window.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle; the block does not enforce it. A sample that
// fires no window leaves the block idle and ready for the next sample. After
// accepting a firing sample s_tready stays low while each lag works through
// max(0, 2*(Nw/2)-2k-1) squared second differences (three RAM reads, a 26x26
// square of the magnitude, an add on the single accumulator), four passes of
// 80 quotient bits on the shared bit-serial divider, a set-up and a hand-off.
// The result register lets the next lag, or the next sample, go ahead while
// a result waits; a stalled m_tready stops the sequencer at the next result.
// Reset clears counters and valid flags and loads the window centre with the
// default window size; the ring is not cleared, and is read only where
// samples have been written.
module dynamic_allan_variance_engine_unit #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_WINDOW = 192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // phase_sample[23:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // window_number[23:0], lag[30:24], variance_value[94:31], 0
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    localparam logic [7:0] MAX_WIN = 8'(MAX_WINDOW);

    function automatic logic [7:0] eff_window(input logic [7:0] w);
        logic [7:0] r;
        begin
            r = w;
            if (w < 8'd3)
            begin
                r = 8'd3;
            end
            else if (w > MAX_WIN)
            begin
                r = MAX_WIN;
            end
            return r;
        end
    endfunction

    dav_pkg::state_t state_reg, state_next;

    logic [7:0]  win_sz_reg;
    logic [7:0]  step_reg;
    logic [15:0] tau_reg;
    logic [dav_pkg::CNT_W-1:0] rec_len_reg;
    logic [dav_pkg::CNT_W-1:0] count_reg;
    logic [dav_pkg::CNT_W-1:0] centre_reg;
    logic [dav_pkg::CNT_W-1:0] wcount_reg;
    logic [dav_pkg::CNT_W-1:0] win_reg;

    logic [6:0]  half_reg;
    logic [6:0]  lags_reg;
    logic [dav_pkg::LAG_W-1:0] k_reg;
    logic [13:0] kk2_reg;
    logic signed [dav_pkg::POS_W-1:0]  m_reg;
    logic signed [dav_pkg::POS_W-1:0]  last_reg;
    logic signed [dav_pkg::DIFF_W-1:0] d_reg;
    logic [dav_pkg::SQ_W-1:0]   sq_reg;
    logic [dav_pkg::SUM_W-1:0]  sum_reg;
    logic [dav_pkg::QUO_W-1:0]  q_reg;
    logic [dav_pkg::DIVR_W-1:0] rem_reg;
    logic [1:0] pass_reg;
    logic [6:0] bit_reg;

    logic        out_valid_reg;
    logic [23:0] out_win_reg;
    logic [6:0]  out_lag_reg;
    logic [63:0] out_val_reg;
    logic        out_last_reg;

    // window limits at the accepted sample
    logic [7:0]  nw_eff;
    logic [6:0]  half_w;
    logic [16:0] lags_prod;
    logic [6:0]  lags_w;
    logic        rec_short;
    logic [dav_pkg::CNT_W-1:0] rec_lim;
    logic [dav_pkg::POS_W-1:0] target;
    logic        fire;
    logic        in_accept;

    always_comb
    begin
        nw_eff    = eff_window(win_sz_reg);
        half_w    = nw_eff[7:1];
        lags_prod = 17'(nw_eff) * 17'd171;
        lags_w    = lags_prod[15:9];
        rec_short = rec_len_reg < 24'(nw_eff);
        rec_lim   = rec_len_reg - 24'(nw_eff);
        target    = 26'(centre_reg) + 26'(half_w) - 26'd2;
        fire      = !rec_short && !(centre_reg > rec_lim) && (26'(count_reg) >= target);
    end

    assign s_tready  = (state_reg == dav_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // lag bounds
    logic signed [dav_pkg::POS_W-1:0] first_w, last_w;
    always_comb
    begin
        first_w = $signed(26'(centre_reg)) - $signed(26'(half_reg)) + $signed(26'(k_reg));
        last_w  = $signed(26'(centre_reg)) + $signed(26'(half_reg))
                  - $signed(26'(k_reg)) - 26'sd2;
    end

    // ring RAM
    logic signed [dav_pkg::POS_W-1:0] rd_pos;
    logic [dav_pkg::SAMPLE_W-1:0] rdata;
    logic signed [dav_pkg::DIFF_W-1:0] rd_ext;

    always_comb
    begin
        unique case (state_reg)
            dav_pkg::ST_RD_LO: rd_pos = m_reg - $signed(26'(k_reg));
            dav_pkg::ST_RD_HI: rd_pos = m_reg + $signed(26'(k_reg));
            default:           rd_pos = m_reg;
        endcase
    end

    dav_ram #(
        .WIDTH(dav_pkg::SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (in_accept),
        .waddr(count_reg[AW-1:0]),
        .wdata(s_tdata),
        .raddr(rd_pos[AW-1:0]),
        .rdata(rdata)
    );

    assign rd_ext = $signed(27'($signed(rdata)));

    // magnitude of the second difference, squared unsigned
    logic [dav_pkg::DIFF_W-2:0] d_mag;
    assign d_mag = d_reg[dav_pkg::DIFF_W-1] ? 26'(-d_reg) : 26'(d_reg);

    // shared divider step
    logic [dav_pkg::DIVR_W-1:0] divisor;
    logic [dav_pkg::DIVR_W:0]   rem_sh;
    logic                       rem_ge;
    logic [dav_pkg::DIVR_W:0]   rem_sub;

    always_comb
    begin
        unique case (dav_pkg::div_pass_t'(pass_reg))
            dav_pkg::PASS_LAG:   divisor = 24'(kk2_reg);
            dav_pkg::PASS_TAU_A: divisor = 24'(tau_reg);
            dav_pkg::PASS_TAU_B: divisor = 24'(tau_reg);
            dav_pkg::PASS_LEN:   divisor = rec_len_reg - {16'd0, k_reg, 1'b0};
            default:             divisor = 24'(tau_reg);
        endcase
        rem_sh  = {rem_reg, q_reg[dav_pkg::QUO_W-1]};
        rem_ge  = rem_sh >= {1'b0, divisor};
        rem_sub = rem_sh - {1'b0, divisor};
    end

    logic out_free;
    logic lag_done;
    logic div_last;
    logic sat;
    logic [24:0] centre_sum;

    assign out_free   = !out_valid_reg || m_tready;
    assign lag_done   = (k_reg == lags_reg);
    assign div_last   = (bit_reg == 7'(dav_pkg::QUO_W - 1));
    assign sat        = (q_reg[dav_pkg::QUO_W-1:dav_pkg::VAL_W] != '0) || (tau_reg == '0);
    assign centre_sum = 25'(centre_reg) + 25'((step_reg == 8'd0) ? 8'd1 : step_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dav_pkg::ST_IDLE:
            begin
                if (in_accept && fire)
                begin
                    state_next = dav_pkg::ST_LAG;
                end
            end
            dav_pkg::ST_LAG:
            begin
                state_next = (first_w > last_w) ? dav_pkg::ST_DIV : dav_pkg::ST_RD_LO;
            end
            dav_pkg::ST_RD_LO:  state_next = dav_pkg::ST_RD_MID;
            dav_pkg::ST_RD_MID: state_next = dav_pkg::ST_RD_HI;
            dav_pkg::ST_RD_HI:  state_next = dav_pkg::ST_SUM_D;
            dav_pkg::ST_SUM_D:  state_next = dav_pkg::ST_SQUARE;
            dav_pkg::ST_SQUARE: state_next = dav_pkg::ST_ACC;
            dav_pkg::ST_ACC:
            begin
                state_next = (m_reg == last_reg) ? dav_pkg::ST_DIV : dav_pkg::ST_RD_LO;
            end
            dav_pkg::ST_DIV:
            begin
                if (div_last && pass_reg == 2'(dav_pkg::PASS_LEN))
                begin
                    state_next = dav_pkg::ST_EMIT;
                end
            end
            dav_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lag_done ? dav_pkg::ST_IDLE : dav_pkg::ST_LAG;
                end
            end
            default: state_next = dav_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dav_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_sz_reg    <= 8'd100;
            step_reg      <= 8'd10;
            tau_reg       <= 16'd1;
            rec_len_reg   <= 24'd1000;
            count_reg     <= '0;
            centre_reg    <= 24'(eff_window(8'd100));
            wcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (dav_pkg::reg_index_t'(cfg_index))
                    dav_pkg::REG_WINDOW_SIZE:
                    begin
                        win_sz_reg <= cfg_data[7:0];
                        if (count_reg == '0 && wcount_reg == '0)
                        begin
                            centre_reg <= 24'(eff_window(cfg_data[7:0]));
                        end
                    end
                    dav_pkg::REG_STEP_SIZE:       step_reg    <= cfg_data[7:0];
                    dav_pkg::REG_SAMPLE_INTERVAL: tau_reg     <= cfg_data[15:0];
                    dav_pkg::REG_RECORD_LENGTH:   rec_len_reg <= cfg_data;
                    default:                      step_reg    <= step_reg;
                endcase
            end

            if (in_accept && count_reg != dav_pkg::CNT_MAX)
            begin
                count_reg <= count_reg + 24'd1;
            end

            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == dav_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (lag_done)
                begin
                    wcount_reg <= win_reg;
                    centre_reg <= centre_sum[24] ? dav_pkg::CNT_MAX : centre_sum[23:0];
                end
            end
        end
    end

    // datapath: sums, divider and result payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dav_pkg::ST_IDLE:
            begin
                win_reg  <= wcount_reg + 24'd1;
                half_reg <= half_w;
                lags_reg <= lags_w;
                k_reg    <= 7'd1;
            end
            dav_pkg::ST_LAG:
            begin
                m_reg    <= first_w;
                last_reg <= last_w;
                sum_reg  <= '0;
                kk2_reg  <= {13'(k_reg) * 13'(k_reg), 1'b0};
                q_reg    <= '0;
                rem_reg  <= '0;
                pass_reg <= 2'(dav_pkg::PASS_LAG);
                bit_reg  <= '0;
            end
            dav_pkg::ST_RD_MID: d_reg <= rd_ext;
            dav_pkg::ST_RD_HI:  d_reg <= d_reg - (rd_ext <<< 1);
            dav_pkg::ST_SUM_D:  d_reg <= d_reg + rd_ext;
            dav_pkg::ST_SQUARE: sq_reg <= d_mag * d_mag;
            dav_pkg::ST_ACC:
            begin
                sum_reg <= sum_reg + 60'(sq_reg);
                m_reg   <= m_reg + 26'sd1;
                q_reg   <= 80'({sum_reg + 60'(sq_reg), 16'd0});
            end
            dav_pkg::ST_DIV:
            begin
                q_reg   <= {q_reg[dav_pkg::QUO_W-2:0], rem_ge};
                rem_reg <= rem_ge ? rem_sub[dav_pkg::DIVR_W-1:0]
                                  : rem_sh[dav_pkg::DIVR_W-1:0];
                bit_reg <= bit_reg + 7'd1;
                if (div_last)
                begin
                    bit_reg  <= '0;
                    rem_reg  <= '0;
                    pass_reg <= pass_reg + 2'd1;
                end
            end
            dav_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_win_reg  <= win_reg;
                    out_lag_reg  <= k_reg;
                    out_val_reg  <= sat ? {dav_pkg::VAL_W{1'b1}}
                                        : q_reg[dav_pkg::VAL_W-1:0];
                    out_last_reg <= lag_done;
                    k_reg        <= k_reg + 7'd1;
                end
            end
            default: d_reg <= d_reg;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_val_reg, out_lag_reg, out_win_reg};
    assign m_tlast  = out_last_reg;

endmodule
